/* rtl/mesws_pkg.sv */
// shared types, constants and defaults for the multichannel ema smoother
package mesws_pkg;

  localparam int DEF_CHAIN_COUNT   = 2;
  localparam int DEF_CHANNEL_COUNT = 16;
  localparam int DEF_SAMPLE_BITS   = 16;

  localparam int ACTION_BITS  = 2;
  localparam int CHAIN_BITS   = 1;
  localparam int CHANNEL_BITS = 4;
  localparam int RATE_BITS    = 16;
  localparam int THRESH_BITS  = 16;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [THRESH_BITS-1:0] SNAP_THRESHOLD_RST = 16'd3277;
  localparam logic [RATE_BITS-1:0]   SMOOTHING_RATE_RST = 16'd6554;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_UPDATE = 2'd0,
    ACT_SEED   = 2'd1,
    ACT_READ   = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SNAP_THRESHOLD = 1'b0,
    REG_SMOOTHING_RATE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [THRESH_BITS-1:0] snap_threshold;
    logic [RATE_BITS-1:0]   smoothing_rate;
  } cfg_t;

endpackage

/* rtl/mesws_if.sv */
// channel interfaces: input requests, results and configuration writes
interface mesws_in_if #(
  parameter int SAMPLE_BITS = mesws_pkg::DEF_SAMPLE_BITS
);
  logic                                valid;
  logic                                ready;
  logic [mesws_pkg::ACTION_BITS-1:0]   action;
  logic [mesws_pkg::CHAIN_BITS-1:0]    chain_index;
  logic [mesws_pkg::CHANNEL_BITS-1:0]  channel_index;
  logic [SAMPLE_BITS-1:0]              sample_value;

  modport source (output valid, action, chain_index, channel_index, sample_value,
                  input ready);
  modport sink   (input valid, action, chain_index, channel_index, sample_value,
                  output ready);
endinterface

interface mesws_out_if #(
  parameter int SAMPLE_BITS = mesws_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic [SAMPLE_BITS-1:0]        smoothed_value;
  logic signed [SAMPLE_BITS:0]   change_since_last;

  modport source (output valid, smoothed_value, change_since_last, input ready);
  modport sink   (input valid, smoothed_value, change_since_last, output ready);
endinterface

interface mesws_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [mesws_pkg::CFG_IDX_BITS-1:0]    index;
  logic [mesws_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/multichannel_ema_smoother_with_snap.sv */
// top level: multichannel exponential moving average smoother with snap
//
//   channel  dir  contents
//   items    in   action, chain_index, channel_index, sample_value
//   results  out  smoothed_value, change_since_last
//   cfg      in   index (0 snap threshold, 1 smoothing rate), data
//
// one request a cycle while results are taken; the accepting edge loads the input
// register, and the slot read-modify-write then runs from it into the result
// register as soon as that register is free or draining
// the slot update reads and writes the store in the same cycle, so the next
// request in the input register always sees the updated slot
// rst is synchronous: clears both stores, restores register defaults
// a stalled result holds; requests keep coming in while the input register is free or moving on
module multichannel_ema_smoother_with_snap #(
  parameter int CHAIN_COUNT   = mesws_pkg::DEF_CHAIN_COUNT,
  parameter int CHANNEL_COUNT = mesws_pkg::DEF_CHANNEL_COUNT
) (
  input  logic         clk,
  input  logic         rst,
  mesws_in_if.sink     items,
  mesws_out_if.source  results,
  mesws_cfg_if.sink    cfg
);

  // sample width is the package default, as are the channel interface defaults
  localparam int SAMPLE_BITS = mesws_pkg::DEF_SAMPLE_BITS;
  localparam int SLOT_COUNT  = CHAIN_COUNT * CHANNEL_COUNT;
  localparam int SLOT_BITS   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // configuration registers
  mesws_pkg::cfg_t regs;

  mesws_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // input register
  logic                                 req_valid;
  mesws_pkg::action_t                   req_action;
  logic [mesws_pkg::CHAIN_BITS-1:0]     req_chain;
  logic [mesws_pkg::CHANNEL_BITS-1:0]   req_channel;
  logic [SAMPLE_BITS-1:0]               req_sample;

  // result register
  logic                                 res_valid;
  logic [SAMPLE_BITS-1:0]               res_smoothed;
  logic signed [SAMPLE_BITS:0]          res_change;

  logic advance;
  logic items_take;

  // the update stage moves whenever the result register is free or draining
  assign advance    = !res_valid || results.ready;
  assign items.ready = !req_valid || advance;
  assign items_take = items.valid && items.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (items.ready) begin
      req_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items_take) begin
      req_action  <= mesws_pkg::action_t'(items.action);
      req_chain   <= items.chain_index;
      req_channel <= items.channel_index;
      req_sample  <= items.sample_value;
    end
  end

  // slot decode: chain * CHANNEL_COUNT + channel, with range check
  logic [31:0]          slot_full;
  logic [SLOT_BITS-1:0] slot;
  logic                 in_range;

  assign slot_full = 32'(req_chain) * 32'(CHANNEL_COUNT) + 32'(req_channel);
  assign slot      = slot_full[SLOT_BITS-1:0];
  assign in_range  = (32'(req_chain) < 32'(CHAIN_COUNT)) &&
                     (32'(req_channel) < 32'(CHANNEL_COUNT));

  // slot stores
  logic [SAMPLE_BITS-1:0]      rd_avg;
  logic [SAMPLE_BITS-1:0]      rd_prev;
  logic                        upd_wr_en;
  logic [SAMPLE_BITS-1:0]      upd_avg;
  logic [SAMPLE_BITS-1:0]      upd_prev;
  logic [SAMPLE_BITS-1:0]      upd_smoothed;
  logic signed [SAMPLE_BITS:0] upd_change;

  mesws_slot_store #(
    .SLOT_COUNT  (SLOT_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SLOT_BITS   (SLOT_BITS)
  ) u_slot_store (
    .clk     (clk),
    .rst     (rst),
    .rd_slot (slot),
    .rd_avg  (rd_avg),
    .rd_prev (rd_prev),
    .wr_en   (upd_wr_en && req_valid && advance),
    .wr_slot (slot),
    .wr_avg  (upd_avg),
    .wr_prev (upd_prev)
  );

  // snap-or-blend arithmetic for the request in the input register
  mesws_update #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_update (
    .action   (req_action),
    .in_range (in_range),
    .sample   (req_sample),
    .avg      (rd_avg),
    .prev     (rd_prev),
    .regs     (regs),
    .wr_en    (upd_wr_en),
    .new_avg  (upd_avg),
    .new_prev (upd_prev),
    .smoothed (upd_smoothed),
    .change   (upd_change)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && req_valid) begin
      res_smoothed <= upd_smoothed;
      res_change   <= upd_change;
    end
  end

  assign results.valid             = res_valid;
  assign results.smoothed_value    = res_smoothed;
  assign results.change_since_last = res_change;

endmodule

/* rtl/mesws_cfg_regs.sv */
// snap threshold and smoothing rate registers with their write port
module mesws_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  mesws_cfg_if.sink        cfg,
  output mesws_pkg::cfg_t  regs
);

  mesws_pkg::cfg_t regs_next;

  assign cfg.ready = 1'b1;

  always_comb begin
    regs_next = regs;
    if (cfg.valid) begin
      case (mesws_pkg::cfg_reg_t'(cfg.index))
        mesws_pkg::REG_SNAP_THRESHOLD: regs_next.snap_threshold = cfg.data;
        mesws_pkg::REG_SMOOTHING_RATE: regs_next.smoothing_rate = cfg.data;
        default: regs_next = regs;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.snap_threshold <= mesws_pkg::SNAP_THRESHOLD_RST;
      regs.smoothing_rate <= mesws_pkg::SMOOTHING_RATE_RST;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

/* rtl/mesws_slot_store.sv */
// per-slot average and previous-average registers, one read and one write port
module mesws_slot_store #(
  parameter int SLOT_COUNT  = mesws_pkg::DEF_CHAIN_COUNT * mesws_pkg::DEF_CHANNEL_COUNT,
  parameter int SAMPLE_BITS = mesws_pkg::DEF_SAMPLE_BITS,
  parameter int SLOT_BITS   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SLOT_BITS-1:0]   rd_slot,
  output logic [SAMPLE_BITS-1:0] rd_avg,
  output logic [SAMPLE_BITS-1:0] rd_prev,
  input  logic                   wr_en,
  input  logic [SLOT_BITS-1:0]   wr_slot,
  input  logic [SAMPLE_BITS-1:0] wr_avg,
  input  logic [SAMPLE_BITS-1:0] wr_prev
);

  logic [SAMPLE_BITS-1:0] avg_mem  [SLOT_COUNT];
  logic [SAMPLE_BITS-1:0] prev_mem [SLOT_COUNT];

  // out-of-range slots are never written and read data is then ignored
  assign rd_avg  = avg_mem[rd_slot];
  assign rd_prev = prev_mem[rd_slot];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        avg_mem[i]  <= '0;
        prev_mem[i] <= '0;
      end
    end else if (wr_en) begin
      avg_mem[wr_slot]  <= wr_avg;
      prev_mem[wr_slot] <= wr_prev;
    end
  end

endmodule

/* rtl/mesws_update.sv */
// snap-or-blend update of one slot and the result it returns
module mesws_update #(
  parameter int SAMPLE_BITS = mesws_pkg::DEF_SAMPLE_BITS
) (
  input  mesws_pkg::action_t           action,
  input  logic                         in_range,
  input  logic [SAMPLE_BITS-1:0]       sample,
  input  logic [SAMPLE_BITS-1:0]       avg,
  input  logic [SAMPLE_BITS-1:0]       prev,
  input  mesws_pkg::cfg_t              regs,
  output logic                         wr_en,
  output logic [SAMPLE_BITS-1:0]       new_avg,
  output logic [SAMPLE_BITS-1:0]       new_prev,
  output logic [SAMPLE_BITS-1:0]       smoothed,
  output logic signed [SAMPLE_BITS:0]  change
);

  localparam int CMP_BITS  = (SAMPLE_BITS > mesws_pkg::THRESH_BITS) ?
                             SAMPLE_BITS : mesws_pkg::THRESH_BITS;
  localparam int PROD_BITS = SAMPLE_BITS + mesws_pkg::RATE_BITS + 2;

  logic signed [SAMPLE_BITS:0]    diff;
  logic [SAMPLE_BITS-1:0]         err;
  logic                           snap;
  logic signed [PROD_BITS-1:0]    prod;
  logic signed [SAMPLE_BITS+1:0]  step;
  logic signed [SAMPLE_BITS+1:0]  blend_sum;
  logic [SAMPLE_BITS-1:0]         blended;

  // avg*2^16 + rate*(sample-avg), floored by the arithmetic shift
  assign diff = $signed({1'b0, sample}) - $signed({1'b0, avg});
  assign err  = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : diff[SAMPLE_BITS-1:0];
  assign snap = CMP_BITS'(err) > CMP_BITS'(regs.snap_threshold);

  assign prod      = $signed({1'b0, regs.smoothing_rate}) * diff;
  assign step      = prod[PROD_BITS-1:mesws_pkg::RATE_BITS];
  assign blend_sum = $signed({2'b00, avg}) + step;
  assign blended   = blend_sum[SAMPLE_BITS-1:0];

  always_comb begin
    wr_en    = 1'b0;
    new_avg  = avg;
    new_prev = prev;
    case (action)
      mesws_pkg::ACT_UPDATE: begin
        wr_en    = in_range;
        new_prev = avg;
        new_avg  = snap ? sample : blended;
      end
      mesws_pkg::ACT_SEED: begin
        wr_en    = in_range;
        new_prev = sample;
        new_avg  = sample;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase

    if (in_range) begin
      smoothed = new_avg;
      change   = $signed({1'b0, new_avg}) - $signed({1'b0, new_prev});
    end else begin
      smoothed = '0;
      change   = '0;
    end
  end

endmodule

/* test/multichannel_ema_smoother_with_snap_test.sv */
// self-checking testbench for the multichannel ema smoother with snap threshold
module multichannel_ema_smoother_with_snap_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = mesws_pkg::DEF_CHAIN_COUNT * mesws_pkg::DEF_CHANNEL_COUNT;
  localparam int SB = mesws_pkg::DEF_SAMPLE_BITS;
  localparam int FULL_SCALE = (1 << SB) - 1;
  // spare action code, the block treats it as a read
  localparam logic [mesws_pkg::ACTION_BITS-1:0] ACT_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int LONG_HOLD_AT = 400;
  localparam int PHASE_REQUESTS = 105;
  localparam int PHASES = 8;

  typedef struct {
    logic [mesws_pkg::ACTION_BITS-1:0]  action;
    logic [mesws_pkg::CHAIN_BITS-1:0]   chain;
    logic [mesws_pkg::CHANNEL_BITS-1:0] channel;
    logic [SB-1:0]                      sample;
  } smoother_request_t;

  typedef struct {
    logic [SB-1:0] smoothed;
    logic [SB:0]   change;
  } smoother_result_t;

  logic clk;
  logic rst;

  mesws_in_if  items_ch ();
  mesws_out_if results_ch ();
  mesws_cfg_if cfg_ch ();

  multichannel_ema_smoother_with_snap dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  // requests waiting for the driver, and results the block still owes us
  smoother_request_t pending_requests[$];
  smoother_result_t  awaited_results[$];

  // predictor state: mirror of both slot stores and of the two registers
  logic [SB-1:0]                     average_mirror [SLOTS];
  logic [SB-1:0]                     previous_mirror [SLOTS];
  logic [mesws_pkg::THRESH_BITS-1:0] threshold_mirror;
  logic [mesws_pkg::RATE_BITS-1:0]   rate_mirror;

  int    failures = 0;
  int    queued_count = 0;
  int    accepted_count = 0;
  int    stall_cycles = 0;
  logic  request_taken = 1'b0;

  // sender burst shaping
  int    burst_left = 1;
  int    gap_left = 0;

  // receiver stall shaping
  int    recv_cycle = 0;
  int    recv_mode = 0;
  int    long_hold_left = 0;
  bit    long_hold_done = 1'b0;

  // stimulus-side view of where each slot's average roughly sits
  int    slot_level [SLOTS];
  int    threshold_now;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one slot action: read-modify-write of the mirrored stores
  function automatic smoother_result_t predict_smoothing(smoother_request_t req);
    int unsigned      slot;
    logic [SB-1:0]    avg;
    logic [SB-1:0]    err;
    logic [SB+17:0]   acc;
    smoother_result_t res;
    slot = int'(req.chain) * mesws_pkg::DEF_CHANNEL_COUNT + int'(req.channel);
    avg = average_mirror[slot];
    case (req.action)
      mesws_pkg::ACT_UPDATE: begin
        previous_mirror[slot] = avg;
        err = (req.sample >= avg) ? req.sample - avg : avg - req.sample;
        // strictly above the threshold snaps, equal still blends
        if (err > threshold_mirror) begin
          average_mirror[slot] = req.sample;
        end else begin
          acc = (SB+18)'(rate_mirror) * (SB+18)'(req.sample)
              + ((SB+18)'(1 << 16) - (SB+18)'(rate_mirror)) * (SB+18)'(avg);
          average_mirror[slot] = acc[SB+15:16];
        end
      end
      mesws_pkg::ACT_SEED: begin
        average_mirror[slot]  = req.sample;
        previous_mirror[slot] = req.sample;
      end
      default: begin
        // read and the spare code leave the slot alone
      end
    endcase
    res.smoothed = average_mirror[slot];
    res.change   = {1'b0, average_mirror[slot]} - {1'b0, previous_mirror[slot]};
    return res;
  endfunction

  // monitor: register mirror, prediction on each accepted request, result check
  always @(posedge clk) begin : monitor
    smoother_request_t req;
    smoother_result_t  want;
    bit                moved;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        average_mirror[i]  = '0;
        previous_mirror[i] = '0;
      end
      threshold_mirror = mesws_pkg::SNAP_THRESHOLD_RST;
      rate_mirror      = mesws_pkg::SMOOTHING_RATE_RST;
      request_taken    = 1'b0;
      stall_cycles     = 0;
    end else begin
      moved = 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        case (cfg_ch.index)
          mesws_pkg::REG_SNAP_THRESHOLD: threshold_mirror = cfg_ch.data;
          mesws_pkg::REG_SMOOTHING_RATE: rate_mirror = cfg_ch.data;
          default: ;
        endcase
      end
      if (results_ch.valid && results_ch.ready) begin
        moved = 1'b1;
        if (awaited_results.size() == 0) begin
          $display("%0t: result with nothing awaited, got smoothed %h change %h",
                   $time, results_ch.smoothed_value, results_ch.change_since_last);
          failures++;
        end else begin
          want = awaited_results.pop_front();
          if (results_ch.smoothed_value !== want.smoothed) begin
            $display("%0t: smoothed_value expected %h got %h",
                     $time, want.smoothed, results_ch.smoothed_value);
            failures++;
          end
          if (results_ch.change_since_last !== want.change) begin
            $display("%0t: change_since_last expected %h got %h",
                     $time, want.change, results_ch.change_since_last);
            failures++;
          end
        end
      end
      request_taken = items_ch.valid && items_ch.ready;
      if (request_taken) begin
        moved = 1'b1;
        req.action  = items_ch.action;
        req.chain   = items_ch.chain_index;
        req.channel = items_ch.channel_index;
        req.sample  = items_ch.sample_value;
        awaited_results.push_back(predict_smoothing(req));
        accepted_count++;
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  // driver: bursts of requests with random gaps, holding each until taken
  always @(negedge clk) begin : request_driver
    smoother_request_t req;
    if (rst) begin
      items_ch.valid <= 1'b0;
    end else if (items_ch.valid && !request_taken) begin
      // stalled by the block, keep the request on the bus
    end else if (gap_left > 0) begin
      gap_left--;
      items_ch.valid <= 1'b0;
    end else if (pending_requests.size() > 0) begin
      req = pending_requests.pop_front();
      items_ch.valid         <= 1'b1;
      items_ch.action        <= req.action;
      items_ch.chain_index   <= req.chain;
      items_ch.channel_index <= req.channel;
      items_ch.sample_value  <= req.sample;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        // a quarter of bursts run straight into the next one
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end else begin
      items_ch.valid <= 1'b0;
    end
  end

  // receiver: a randomly drawn stall pattern, redrawn as recv_cycle advances, plus one long hold-off
  always @(negedge clk) begin : result_receiver
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else begin
      recv_cycle++;
      if (recv_cycle % 64 == 0) begin
        recv_mode = $urandom_range(0, 3);
      end
      // once, mid-run, hold off long enough for the block to back up
      if (!long_hold_done && accepted_count >= LONG_HOLD_AT) begin
        long_hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        results_ch.ready <= 1'b0;
      end else begin
        case (recv_mode)
          0: results_ch.ready <= 1'b1;
          1: results_ch.ready <= 1'($urandom_range(0, 1));
          2: results_ch.ready <= (recv_cycle % 5 == 0);
          default: results_ch.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // give up when nothing moves on any channel for too long
  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic write_register(mesws_pkg::cfg_reg_t idx,
                                logic [mesws_pkg::CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == mesws_pkg::REG_SNAP_THRESHOLD) begin
      threshold_now = value;
    end
  endtask

  task automatic queue_request(logic [mesws_pkg::ACTION_BITS-1:0] act, int chain,
                               int channel, int sample);
    smoother_request_t req;
    req.action  = act;
    req.chain   = mesws_pkg::CHAIN_BITS'(chain);
    req.channel = mesws_pkg::CHANNEL_BITS'(channel);
    req.sample  = SB'(sample);
    pending_requests.push_back(req);
    queued_count++;
  endtask

  // sender pause: every request taken and every result back
  task automatic wait_drained();
    while (accepted_count != queued_count || awaited_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // mostly samples near the slot's level so the blend path and the threshold
  // boundary get hit, the rest far away or at full-scale extremes
  task automatic queue_random_request();
    int                                pick;
    int                                slot;
    int                                span;
    int                                target;
    logic [mesws_pkg::ACTION_BITS-1:0] act;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      act = mesws_pkg::ACT_UPDATE;
    end else if (pick < 72) begin
      act = mesws_pkg::ACT_SEED;
    end else if (pick < 92) begin
      act = mesws_pkg::ACT_READ;
    end else begin
      act = ACT_SPARE;
    end
    // half the traffic on a few slots, so one slot sees back-to-back requests
    slot = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, SLOTS - 1);
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      span = (threshold_now < 8000) ? threshold_now + 2 : 8000;
      target = $urandom_range(0, span);
      target = $urandom_range(0, 1) ? slot_level[slot] + target : slot_level[slot] - target;
      if (target < 0) begin
        target = 0;
      end
      if (target > FULL_SCALE) begin
        target = FULL_SCALE;
      end
    end else begin
      target = (pick < 8) ? $urandom_range(0, FULL_SCALE)
                          : ($urandom_range(0, 1) ? FULL_SCALE : 0);
      if (act == mesws_pkg::ACT_UPDATE) begin
        slot_level[slot] = target;
      end
    end
    if (act == mesws_pkg::ACT_SEED) begin
      slot_level[slot] = target;
    end
    queue_request(act, slot / mesws_pkg::DEF_CHANNEL_COUNT,
                  slot % mesws_pkg::DEF_CHANNEL_COUNT, target);
  endtask

  initial begin : stimulus
    int thr_plan [PHASES];
    int rate_plan [PHASES];
    rst = 1'b1;
    items_ch.valid         = 1'b0;
    items_ch.action        = '0;
    items_ch.chain_index   = '0;
    items_ch.channel_index = '0;
    items_ch.sample_value  = '0;
    results_ch.ready       = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = mesws_pkg::REG_SNAP_THRESHOLD;
    cfg_ch.data            = '0;
    threshold_now          = mesws_pkg::SNAP_THRESHOLD_RST;
    for (int i = 0; i < SLOTS; i++) begin
      slot_level[i] = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset register values: empty slots, snaps both ways, equal error
    queue_request(mesws_pkg::ACT_READ, 0, 0, 0);
    queue_request(mesws_pkg::ACT_READ, 1, 15, FULL_SCALE);
    queue_request(mesws_pkg::ACT_UPDATE, 0, 0, 0);
    queue_request(mesws_pkg::ACT_UPDATE, 0, 0, FULL_SCALE);
    queue_request(mesws_pkg::ACT_UPDATE, 0, 0, 0);
    queue_request(mesws_pkg::ACT_SEED, 0, 5, 1000);
    queue_request(mesws_pkg::ACT_UPDATE, 0, 5, 1000 + mesws_pkg::SNAP_THRESHOLD_RST);
    queue_request(mesws_pkg::ACT_UPDATE, 0, 5, 5000);
    queue_request(ACT_SPARE, 0, 5, FULL_SCALE);
    queue_request(mesws_pkg::ACT_SEED, 1, 15, FULL_SCALE);
    queue_request(mesws_pkg::ACT_UPDATE, 1, 15,
                  FULL_SCALE - mesws_pkg::SNAP_THRESHOLD_RST - 1);
    queue_request(mesws_pkg::ACT_READ, 1, 15, 0);
    queue_request(mesws_pkg::ACT_UPDATE, 1, 15, 16'h5555);
    queue_request(mesws_pkg::ACT_SEED, 1, 10, 16'hAAAA);
    wait_drained();

    // rate zero holds the average, no snap at all
    write_register(mesws_pkg::REG_SNAP_THRESHOLD, 16'hFFFF);
    write_register(mesws_pkg::REG_SMOOTHING_RATE, 16'h0000);
    queue_request(mesws_pkg::ACT_UPDATE, 1, 10, 0);
    queue_request(mesws_pkg::ACT_UPDATE, 1, 10, FULL_SCALE);
    wait_drained();

    // zero threshold: any error snaps, zero error still blends
    write_register(mesws_pkg::REG_SNAP_THRESHOLD, 16'h0000);
    write_register(mesws_pkg::REG_SMOOTHING_RATE, 16'hFFFF);
    queue_request(mesws_pkg::ACT_UPDATE, 0, 0, 0);
    queue_request(mesws_pkg::ACT_UPDATE, 0, 0, 1);
    queue_request(mesws_pkg::ACT_SEED, 0, 1, 0);
    wait_drained();

    // full rate blend falls one short of full scale
    write_register(mesws_pkg::REG_SNAP_THRESHOLD, 16'hFFFF);
    queue_request(mesws_pkg::ACT_UPDATE, 0, 1, FULL_SCALE);
    queue_request(mesws_pkg::ACT_UPDATE, 0, 1, FULL_SCALE);
    queue_request(mesws_pkg::ACT_READ, 0, 1, 0);
    wait_drained();

    // random phases, each under its own register setting
    thr_plan  = '{mesws_pkg::SNAP_THRESHOLD_RST, 0, FULL_SCALE, FULL_SCALE,
                  $urandom_range(0, 4000), $urandom_range(0, FULL_SCALE), 1000,
                  $urandom_range(0, 8000)};
    rate_plan = '{mesws_pkg::SMOOTHING_RATE_RST, FULL_SCALE, 0, FULL_SCALE,
                  $urandom_range(0, FULL_SCALE), 1, 32768,
                  $urandom_range(0, FULL_SCALE)};
    for (int p = 0; p < PHASES; p++) begin
      write_register(mesws_pkg::REG_SNAP_THRESHOLD,
                     mesws_pkg::CFG_DATA_BITS'(thr_plan[p]));
      write_register(mesws_pkg::REG_SMOOTHING_RATE,
                     mesws_pkg::CFG_DATA_BITS'(rate_plan[p]));
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        queue_random_request();
      end
      wait_drained();
    end

    // tail: let any stray result show up before the verdict
    repeat (10) @(negedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/mesws_pkg.sv
rtl/mesws_if.sv
rtl/mesws_cfg_regs.sv
rtl/mesws_slot_store.sv
rtl/mesws_update.sv
rtl/multichannel_ema_smoother_with_snap.sv
test/multichannel_ema_smoother_with_snap_test.sv
